// ===== rtl/framed_message_ring_unit_defines.svh =====
// Assertion macros for the framed message ring unit
`ifndef FRAMED_MESSAGE_RING_UNIT_DEFINES_SVH
`define FRAMED_MESSAGE_RING_UNIT_DEFINES_SVH

// cons must hold in the same cycle as ante
`define FMRU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define FMRU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fmru_pkg.sv =====
// Types and constants shared by the framed message ring unit
`timescale 1ns / 1ps
package fmru_pkg;

	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 12;
	localparam int RS_W     = 13;

	localparam logic [FUNC_W-1:0] FUNC_SEND_START = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SEND_BYTE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ_START = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_READ_BYTE  = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_ROOM = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_SEQ     = 2'd3;

	// what the result registers take on a finish
	localparam logic [1:0] RK_NONE = 2'd0;
	localparam logic [1:0] RK_HDR  = 2'd1;
	localparam logic [1:0] RK_BYTE = 2'd2;

	localparam logic [RS_W-1:0] RING_SIZE_RESET = 13'd4096;

	// header byte positions
	localparam int HDR_IDX_RPORT  = 0;
	localparam int HDR_IDX_SENDER = 1;
	localparam int HDR_IDX_LEN_LO = 2;
	localparam int HDR_IDX_LEN_HI = 3;
	localparam int HDR_RD_BYTES   = 4;

	typedef struct packed {
		logic                load;
		logic                byte_wr;
		logic                hdr_wr;
		logic                send_commit;
		logic                rd_issue;
		logic                hdr_take;
		logic                byte_take;
		logic                res_load;
		logic [STATUS_W-1:0] res_status;
		logic [1:0]          res_kind;
	} fmru_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              send_open;
		logic              read_open;
		logic              byte_ready;
		logic              no_room;
		logic              avail_short;
		logic              frame_short;
		logic              idx_last_wr;
		logic              idx_last_rd;
	} fmru_stat_t;

endpackage

// ===== rtl/fmru_ram.sv =====
// Generic single write, single read RAM with registered read data
`timescale 1ns / 1ps
module fmru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/fmru_ctrl.sv =====
// Sequencer for the framed message ring unit
`timescale 1ns / 1ps
module fmru_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  fmru_pkg::fmru_stat_t stat,
	output fmru_pkg::fmru_cmd_t  cmd,
	output logic                busy,
	output logic                done
);
	import fmru_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_EVAL    = 3'd1;
	localparam logic [2:0] ST_HDR_WR  = 3'd2;
	localparam logic [2:0] ST_HDR_RD  = 3'd3;
	localparam logic [2:0] ST_HDR_CHK = 3'd4;
	localparam logic [2:0] ST_BYTE_RD = 3'd5;
	localparam logic [2:0] ST_RESP    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE, ST_RESP: begin
				state_d = ST_IDLE;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ST_RESP;
				case (stat.func)
					FUNC_SEND_START: begin
						if (stat.send_open) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = STATUS_SEQ;
						end else if (stat.no_room) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = STATUS_NO_ROOM;
						end else begin
							state_d = ST_HDR_WR;
						end
					end
					FUNC_SEND_BYTE: begin
						cmd.res_load = 1'b1;
						if (!stat.send_open) begin
							cmd.res_status = STATUS_SEQ;
						end else begin
							cmd.byte_wr    = 1'b1;
							cmd.res_status = STATUS_OK;
						end
					end
					FUNC_READ_START: begin
						if (stat.read_open) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = STATUS_SEQ;
						end else if (stat.avail_short) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = STATUS_EMPTY;
						end else begin
							state_d = ST_HDR_RD;
						end
					end
					FUNC_READ_BYTE: begin
						if (!stat.byte_ready) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = STATUS_SEQ;
						end else begin
							// read address is presented now, data next cycle
							state_d = ST_BYTE_RD;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_HDR_WR: begin
				cmd.hdr_wr = 1'b1;
				if (stat.idx_last_wr) begin
					cmd.send_commit = 1'b1;
					cmd.res_load    = 1'b1;
					cmd.res_status  = STATUS_OK;
					state_d         = ST_RESP;
				end
			end
			ST_HDR_RD: begin
				cmd.rd_issue = 1'b1;
				if (stat.idx_last_rd) begin
					state_d = ST_HDR_CHK;
				end
			end
			ST_HDR_CHK: begin
				cmd.res_load = 1'b1;
				state_d      = ST_RESP;
				if (stat.frame_short) begin
					cmd.res_status = STATUS_EMPTY;
				end else begin
					cmd.hdr_take   = 1'b1;
					cmd.res_status = STATUS_OK;
					cmd.res_kind   = RK_HDR;
				end
			end
			ST_BYTE_RD: begin
				cmd.byte_take  = 1'b1;
				cmd.res_load   = 1'b1;
				cmd.res_status = STATUS_OK;
				cmd.res_kind   = RK_BYTE;
				state_d        = ST_RESP;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign done = (state_q == ST_RESP);
	assign busy = (state_q != ST_IDLE) && (state_q != ST_RESP);

endmodule

// ===== rtl/fmru_dp.sv =====
// Datapath of the framed message ring unit: offsets, counters, ring RAM, results
`timescale 1ns / 1ps
module fmru_dp #(
	parameter int RING_DEPTH   = 4096,
	parameter int HEADER_BYTES = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fmru_pkg::fmru_cmd_t              cmd,
	output fmru_pkg::fmru_stat_t             stat,
	input  logic [fmru_pkg::FUNC_W-1:0]      func,
	input  logic [7:0]                       data_byte,
	input  logic [fmru_pkg::LEN_W-1:0]       message_length,
	input  logic [7:0]                       reply_port,
	input  logic [7:0]                       sender_id,
	input  logic                             cfg_wr,
	input  logic [fmru_pkg::RS_W-1:0]        cfg_data,
	output logic [fmru_pkg::RS_W-1:0]        ring_size,
	output logic [fmru_pkg::STATUS_W-1:0]    status,
	output logic [7:0]                       out_byte,
	output logic [fmru_pkg::LEN_W-1:0]       out_length,
	output logic [7:0]                       out_reply_port,
	output logic [7:0]                       out_sender,
	output logic                             last_byte
);
	import fmru_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam int EW = AW + 1;
	localparam int CW = ((EW > RS_W) ? EW : RS_W) + 1;
	localparam int IW = $clog2(HEADER_BYTES + 1);
	localparam logic [EW-1:0] EFF_RESET =
		EW'((RING_DEPTH < 4096) ? RING_DEPTH : 4096);
	localparam logic [EW-1:0] HB_E = EW'(HEADER_BYTES);
	localparam logic [CW-1:0] HB_C = CW'(HEADER_BYTES);
	localparam logic [IW-1:0] HB_I = IW'(HEADER_BYTES);

	function automatic logic [EW-1:0] eff_of(input logic [RS_W-1:0] rs);
		logic [31:0] v;
		v = 32'(rs);
		if (v < 32'd16) v = 32'd16;
		if (v > 32'(RING_DEPTH)) v = 32'(RING_DEPTH);
		return v[EW-1:0];
	endfunction

	// pos + n modulo r, with pos < r and n <= r
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] pos,
	                                           input logic [IW-1:0] n,
	                                           input logic [EW-1:0] r);
		logic [EW-1:0] s;
		s = {1'b0, pos} + EW'(n);
		if (s >= r) s = s - r;
		return s[AW-1:0];
	endfunction

	logic [RS_W-1:0]     ring_size_q;
	logic [EW-1:0]       eff_q;
	logic [AW-1:0]       ro_q;
	logic [AW-1:0]       wo_q;
	logic [EW-1:0]       free_q;
	logic [EW-1:0]       avail_q;      // bytes of whole messages not yet released
	logic [CW-1:0]       open_total_q; // header plus payload of the open send
	logic [LEN_W-1:0]    send_rem_q;
	logic [LEN_W-1:0]    read_rem_q;
	logic                read_active_q;
	logic [IW-1:0]       idx_q;

	logic [FUNC_W-1:0]   in_func_q;
	logic [7:0]          in_data_q;
	logic [LEN_W-1:0]    in_len_q;
	logic [7:0]          in_rport_q;
	logic [7:0]          in_sender_q;

	logic [7:0]          hdr_rport_q;
	logic [7:0]          hdr_sender_q;
	logic [7:0]          hdr_len_lo_q;
	logic [3:0]          hdr_len_hi_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [7:0]          res_byte_q;
	logic [LEN_W-1:0]    res_len_q;
	logic [7:0]          res_rport_q;
	logic [7:0]          res_sender_q;
	logic                res_last_q;

	logic [CW-1:0]       total;
	logic [LEN_W-1:0]    hl;
	logic [7:0]          hdr_byte;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [7:0]          ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [7:0]          ram_rdata;

	assign total = HB_C + CW'(in_len_q);
	assign hl    = {hdr_len_hi_q, hdr_len_lo_q};

	always_comb begin
		hdr_byte = 8'd0;
		if (idx_q == IW'(HDR_IDX_RPORT)) begin
			hdr_byte = in_rport_q;
		end else if (idx_q == IW'(HDR_IDX_SENDER)) begin
			hdr_byte = in_sender_q;
		end else if (idx_q == IW'(HDR_IDX_LEN_LO)) begin
			hdr_byte = in_len_q[7:0];
		end else if (idx_q == IW'(HDR_IDX_LEN_HI)) begin
			hdr_byte = {4'd0, in_len_q[LEN_W-1:8]};
		end
	end

	assign ram_we    = cmd.hdr_wr | cmd.byte_wr;
	assign ram_waddr = wrap_add(wo_q, idx_q, eff_q);
	assign ram_wdata = cmd.hdr_wr ? hdr_byte : in_data_q;
	assign ram_raddr = wrap_add(ro_q, idx_q, eff_q);

	fmru_ram #(
		.WIDTH(8),
		.DEPTH(RING_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		stat.func        = in_func_q;
		stat.send_open   = (send_rem_q != '0);
		stat.read_open   = read_active_q;
		stat.byte_ready  = read_active_q && (read_rem_q != '0);
		stat.no_room     = CW'(free_q) < total;
		stat.avail_short = avail_q < HB_E;
		stat.frame_short = CW'(avail_q) < (HB_C + CW'(hl));
		stat.idx_last_wr = (idx_q == HB_I - IW'(1));
		stat.idx_last_rd = (idx_q == IW'(HDR_RD_BYTES));
	end

	// item fields, header capture and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_func_q   <= func;
			in_data_q   <= data_byte;
			in_len_q    <= message_length;
			in_rport_q  <= reply_port;
			in_sender_q <= sender_id;
		end
		// read data arrives in the cycle after its address
		if (cmd.rd_issue) begin
			if (idx_q == IW'(HDR_IDX_RPORT + 1)) hdr_rport_q  <= ram_rdata;
			if (idx_q == IW'(HDR_IDX_SENDER + 1)) hdr_sender_q <= ram_rdata;
			if (idx_q == IW'(HDR_IDX_LEN_LO + 1)) hdr_len_lo_q <= ram_rdata;
			if (idx_q == IW'(HDR_IDX_LEN_HI + 1)) hdr_len_hi_q <= ram_rdata[3:0];
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_byte_q   <= 8'd0;
			res_len_q    <= '0;
			res_rport_q  <= 8'd0;
			res_sender_q <= 8'd0;
			res_last_q   <= 1'b0;
			case (cmd.res_kind)
				RK_HDR: begin
					res_len_q    <= hl;
					res_rport_q  <= hdr_rport_q;
					res_sender_q <= hdr_sender_q;
					res_last_q   <= (hl == '0);
				end
				RK_BYTE: begin
					res_byte_q <= ram_rdata;
					res_last_q <= (read_rem_q == LEN_W'(1));
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q   <= RING_SIZE_RESET;
			eff_q         <= EFF_RESET;
			ro_q          <= '0;
			wo_q          <= '0;
			free_q        <= EFF_RESET;
			avail_q       <= '0;
			open_total_q  <= '0;
			send_rem_q    <= '0;
			read_rem_q    <= '0;
			read_active_q <= 1'b0;
			idx_q         <= '0;
		end else if (cfg_wr) begin
			// a new ring size empties the mailbox
			ring_size_q   <= cfg_data;
			eff_q         <= eff_of(cfg_data);
			ro_q          <= '0;
			wo_q          <= '0;
			free_q        <= eff_of(cfg_data);
			avail_q       <= '0;
			open_total_q  <= '0;
			send_rem_q    <= '0;
			read_rem_q    <= '0;
			read_active_q <= 1'b0;
			idx_q         <= '0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.hdr_wr || cmd.rd_issue) begin
				idx_q <= idx_q + IW'(1);
			end

			if (cmd.send_commit) begin
				wo_q       <= wrap_add(wo_q, HB_I, eff_q);
				free_q     <= free_q - total[EW-1:0];
				send_rem_q <= in_len_q;
				if (in_len_q == '0) begin
					avail_q <= avail_q + HB_E;
				end else begin
					open_total_q <= total;
				end
			end

			if (cmd.byte_wr) begin
				wo_q       <= wrap_add(wo_q, IW'(1), eff_q);
				send_rem_q <= send_rem_q - LEN_W'(1);
				if (send_rem_q == LEN_W'(1)) begin
					avail_q <= avail_q + open_total_q[EW-1:0];
				end
			end

			if (cmd.hdr_take) begin
				ro_q          <= wrap_add(ro_q, HB_I, eff_q);
				free_q        <= free_q + HB_E;
				avail_q       <= avail_q - HB_E;
				read_rem_q    <= hl;
				read_active_q <= (hl != '0);
			end

			if (cmd.byte_take) begin
				ro_q          <= wrap_add(ro_q, IW'(1), eff_q);
				free_q        <= free_q + EW'(1);
				avail_q       <= avail_q - EW'(1);
				read_rem_q    <= read_rem_q - LEN_W'(1);
				read_active_q <= (read_rem_q != LEN_W'(1));
			end
		end
	end

	assign ring_size      = ring_size_q;
	assign status         = res_status_q;
	assign out_byte       = res_byte_q;
	assign out_length     = res_len_q;
	assign out_reply_port = res_rport_q;
	assign out_sender     = res_sender_q;
	assign last_byte      = res_last_q;

endmodule

// ===== rtl/framed_message_ring_unit.sv =====
// Framed message ring unit: top level with APB register port and assertions
// Steps: send_byte writes its byte and refusals end in the evaluate state; read_byte takes
// its byte from the registered RAM read; send_start writes the header one byte per cycle, then
// commits; read_start reads the header, then checks the length (a refusal on length ends there).
// No new item is taken while busy; one is taken in the cycle that carries the strobe.
// Reset restores ring_size to 4096 and empties the mailbox; ring RAM contents are kept.
`timescale 1ns / 1ps
`include "framed_message_ring_unit_defines.svh"
module framed_message_ring_unit #(
	parameter int RING_DEPTH   = 4096,
	parameter int HEADER_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [fmru_pkg::FUNC_W-1:0]   func,
	input  logic [7:0]                    data_byte,
	input  logic [fmru_pkg::LEN_W-1:0]    message_length,
	input  logic [7:0]                    reply_port,
	input  logic [7:0]                    sender_id,
	output logic                          done,
	output logic [fmru_pkg::STATUS_W-1:0] status,
	output logic [7:0]                    out_byte,
	output logic [fmru_pkg::LEN_W-1:0]    out_length,
	output logic [7:0]                    out_reply_port,
	output logic [7:0]                    out_sender,
	output logic                          last_byte,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import fmru_pkg::*;

	fmru_cmd_t       cmd;
	fmru_stat_t      stat;
	logic            cfg_wr;
	logic [RS_W-1:0] ring_size;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {{(32 - RS_W){1'b0}}, ring_size};

	fmru_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	fmru_dp #(
		.RING_DEPTH  (RING_DEPTH),
		.HEADER_BYTES(HEADER_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (func),
		.data_byte     (data_byte),
		.message_length(message_length),
		.reply_port    (reply_port),
		.sender_id     (sender_id),
		.cfg_wr        (cfg_wr),
		.cfg_data      (pwdata[RS_W-1:0]),
		.ring_size     (ring_size),
		.status        (status),
		.out_byte      (out_byte),
		.out_length    (out_length),
		.out_reply_port(out_reply_port),
		.out_sender    (out_sender),
		.last_byte     (last_byte)
	);

	`FMRU_ASSERT_NEXT(a_no_strobe_after_accept, start && !busy, !done, "strobe right after accept")
	`FMRU_ASSERT_NEXT(a_single_strobe, done, !done, "two strobes for one item")
	`FMRU_ASSERT_IMP(a_last_needs_ok, done && last_byte, status == STATUS_OK, "last without ok")
	`FMRU_ASSERT_IMP(a_err_byte, done && status != STATUS_OK, out_byte == 8'd0, "error byte set")
	`FMRU_ASSERT_IMP(a_err_len, done && status != STATUS_OK, out_length == '0, "error length set")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the framed message ring unit
`timescale 1ns / 1ps
module tb_top;
	import fmru_pkg::*;

	localparam int RING_DEPTH = 4096;
	localparam int HDR_LEN    = 8;
	localparam logic [2:0] ADDR_RING_SIZE = 3'd0;
	localparam int PHASE_ITEMS = 180;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [7:0]        data;
		logic [LEN_W-1:0]  len;
		logic [7:0]        rport;
		logic [7:0]        sender;
	} mbox_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [7:0]          obyte;
		logic [LEN_W-1:0]    olen;
		logic [7:0]          orp;
		logic [7:0]          osnd;
		logic                last;
	} mbox_res_t;

	typedef struct packed {
		mbox_cmd_t cmd;
		logic      typed;
		mbox_res_t want;
	} script_row_t;

	localparam logic [$bits(mbox_res_t):0] FROM_MODEL = '0;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [FUNC_W-1:0]   func;
	logic [7:0]          data_byte;
	logic [LEN_W-1:0]    message_length;
	logic [7:0]          reply_port;
	logic [7:0]          sender_id;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [7:0]          out_byte;
	logic [LEN_W-1:0]    out_length;
	logic [7:0]          out_reply_port;
	logic [7:0]          out_sender;
	logic                last_byte;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	framed_message_ring_unit #(
		.RING_DEPTH(RING_DEPTH),
		.HEADER_BYTES(HDR_LEN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.data_byte(data_byte),
		.message_length(message_length),
		.reply_port(reply_port),
		.sender_id(sender_id),
		.done(done),
		.status(status),
		.out_byte(out_byte),
		.out_length(out_length),
		.out_reply_port(out_reply_port),
		.out_sender(out_sender),
		.last_byte(last_byte),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// mailbox mirror
	logic [7:0]      ring_mem [RING_DEPTH];
	logic [RS_W-1:0] ring_size_reg;
	int              rd_ofs;
	int              wr_ofs;
	int              cm_ofs;
	int              free_cnt;
	int              snd_left;
	int              rd_left;
	bit              rd_open;

	mbox_res_t results_due [$];
	script_row_t script [$];
	int errors = 0;
	int n_items = 0;
	int n_results = 0;
	int n_ok = 0;
	int n_refused = 0;
	int n_sizes = 1;

	function automatic int ring_span();
		int r;
		r = ring_size_reg;
		if (r < 16) r = 16;
		if (r > RING_DEPTH) r = RING_DEPTH;
		return r;
	endfunction

	function automatic int ring_pos(int pos, int n);
		int r;
		int p;
		r = ring_span();
		p = (pos % r) + (n % r);
		return p >= r ? p - r : p;
	endfunction

	function automatic void mbox_configure(logic [RS_W-1:0] v);
		ring_size_reg = v;
		rd_ofs = 0;
		wr_ofs = 0;
		cm_ofs = 0;
		free_cnt = ring_span();
		snd_left = 0;
		rd_left = 0;
		rd_open = 0;
	endfunction

	// bytes of whole messages the reader may take
	function automatic int committed_bytes();
		int r;
		int used;
		int pend;
		r = ring_span();
		used = r - free_cnt;
		pend = snd_left == 0 ? 0 : ((wr_ofs + r - cm_ofs) % r) + snd_left;
		return used > pend ? used - pend : 0;
	endfunction

	function automatic mbox_res_t mailbox_step(mbox_cmd_t c);
		mbox_res_t r;
		int i;
		int avail;
		int hl;
		logic [7:0] h;
		r = '0;
		r.status = STATUS_OK;
		case (c.func)
			FUNC_SEND_START: begin
				if (snd_left != 0) r.status = STATUS_SEQ;
				else if (free_cnt < HDR_LEN + c.len) r.status = STATUS_NO_ROOM;
				else begin
					for (i = 0; i < HDR_LEN; i++) begin
						case (i)
							HDR_IDX_RPORT:  h = c.rport;
							HDR_IDX_SENDER: h = c.sender;
							HDR_IDX_LEN_LO: h = c.len[7:0];
							HDR_IDX_LEN_HI: h = {4'd0, c.len[11:8]};
							default:        h = 8'd0;
						endcase
						ring_mem[ring_pos(wr_ofs, i)] = h;
					end
					wr_ofs = ring_pos(wr_ofs, HDR_LEN);
					free_cnt -= HDR_LEN + c.len;
					snd_left = c.len;
					if (c.len == 0) cm_ofs = wr_ofs;
				end
			end
			FUNC_SEND_BYTE: begin
				if (snd_left == 0) r.status = STATUS_SEQ;
				else begin
					ring_mem[wr_ofs] = c.data;
					wr_ofs = ring_pos(wr_ofs, 1);
					snd_left--;
					if (snd_left == 0) cm_ofs = wr_ofs;
				end
			end
			FUNC_READ_START: begin
				avail = committed_bytes();
				if (rd_open) r.status = STATUS_SEQ;
				else if (avail < HDR_LEN) r.status = STATUS_EMPTY;
				else begin
					hl = {ring_mem[ring_pos(rd_ofs, HDR_IDX_LEN_HI)][3:0],
						ring_mem[ring_pos(rd_ofs, HDR_IDX_LEN_LO)]};
					if (avail < HDR_LEN + hl) r.status = STATUS_EMPTY;
					else begin
						r.orp = ring_mem[rd_ofs];
						r.osnd = ring_mem[ring_pos(rd_ofs, HDR_IDX_SENDER)];
						r.olen = LEN_W'(hl);
						rd_ofs = ring_pos(rd_ofs, HDR_LEN);
						free_cnt += HDR_LEN;
						rd_left = hl;
						rd_open = hl != 0;
						r.last = hl == 0;
					end
				end
			end
			default: begin
				if (!rd_open || rd_left == 0) r.status = STATUS_SEQ;
				else begin
					r.obyte = ring_mem[rd_ofs];
					rd_ofs = ring_pos(rd_ofs, 1);
					free_cnt++;
					rd_left--;
					rd_open = rd_left != 0;
					r.last = rd_left == 0;
				end
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		mbox_res_t w;
		if (arst_n && done) begin
			n_results++;
			if (status == STATUS_OK) n_ok++;
			else n_refused++;
			if (results_due.size() == 0) begin
				$error("result with no item outstanding: status %0d", status);
				errors++;
			end else begin
				w = results_due.pop_front();
				check_field("status", w.status, status);
				check_field("out_byte", w.obyte, out_byte);
				check_field("out_length", w.olen, out_length);
				check_field("out_reply_port", w.orp, out_reply_port);
				check_field("out_sender", w.osnd, out_sender);
				check_field("last_byte", w.last, last_byte);
			end
		end
	end

	task automatic apply_item(mbox_cmd_t c, logic typed, mbox_res_t want);
		mbox_res_t p;
		@(negedge clk);
		start <= 1'b1;
		func <= c.func;
		data_byte <= c.data;
		message_length <= c.len;
		reply_port <= c.rport;
		sender_id <= c.sender;
		do @(posedge clk); while (busy);
		p = mailbox_step(c);
		results_due.push_back(typed ? want : p);
		n_items++;
	endtask

	task automatic hold_off(int n);
		@(negedge clk) start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic set_ring_size(logic [RS_W-1:0] v);
		while (results_due.size() != 0) @(posedge clk);
		repeat (HDR_LEN + 4) @(posedge clk);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_RING_SIZE;
		pwdata <= {19'd0, v};
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mbox_configure(v);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("ring_size readback", v, prdata[RS_W-1:0]);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		n_sizes++;
	endtask

	// mostly well-formed traffic that follows the mirror's state, some noise
	function automatic mbox_cmd_t next_random_item();
		mbox_cmd_t c;
		int cap;
		int roll;
		int pick_len;
		cap = ring_span() - HDR_LEN;
		if (cap > 48) cap = 48;
		case ($urandom_range(0, 9))
			0: pick_len = 0;
			1: pick_len = cap;
			default: pick_len = $urandom_range(1, cap);
		endcase
		c.func = FUNC_W'($urandom_range(0, 3));
		c.data = 8'($urandom_range(0, 255));
		c.len = LEN_W'($urandom_range(0, 4095));
		c.rport = 8'($urandom_range(0, 255));
		c.sender = 8'($urandom_range(0, 255));
		roll = $urandom_range(0, 99);
		if (roll < 15) begin
			// keep accepted noise sends short so the ring keeps turning over
			if (c.func == FUNC_SEND_START && snd_left == 0
					&& free_cnt >= HDR_LEN + c.len && c.len > cap)
				c.len = LEN_W'(pick_len);
		end else if (snd_left != 0 && roll < (rd_open ? 57 : 80)) begin
			c.func = FUNC_SEND_BYTE;
		end else if (rd_open) begin
			if (roll < 85 || snd_left != 0) c.func = FUNC_READ_BYTE;
			else begin
				c.func = FUNC_SEND_START;
				c.len = LEN_W'(pick_len);
			end
		end else if (snd_left != 0) begin
			c.func = FUNC_READ_START;
		end else if (committed_bytes() == 0 || roll < 57) begin
			c.func = FUNC_SEND_START;
			c.len = LEN_W'(pick_len);
		end else begin
			c.func = FUNC_READ_START;
		end
		return c;
	endfunction

	task automatic run_phase(int count, bit quiet);
		int k;
		for (k = 0; k < count; k++) begin
			if (!quiet && (k / 40) % 2 == 0 && $urandom_range(0, 7) == 0)
				hold_off($urandom_range(1, 15));
			apply_item(next_random_item(), 1'b0, '0);
		end
		hold_off(1);
	endtask

	logic [RS_W-1:0] size_list [8] = '{13'd16, 13'd0, 13'd37, 13'd8191,
		13'd100, 13'd523, 13'd17, 13'd4096};

	initial begin
		script_row_t r;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_SEND_START;
		data_byte = 8'd0;
		message_length = '0;
		reply_port = 8'd0;
		sender_id = 8'd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_RING_SIZE;
		pwdata = 32'd0;
		foreach (ring_mem[k]) ring_mem[k] = 8'd0;
		mbox_configure(RING_SIZE_RESET);

		// columns: func, data, len, rport, sender | typed, status, byte, len, rport, sender, last
		script.push_back({FUNC_READ_BYTE, 8'd0, 12'd0, 8'd0, 8'd0,
			1'b1, STATUS_SEQ, 8'd0, 12'd0, 8'd0, 8'd0, 1'b0});
		script.push_back({FUNC_SEND_BYTE, 8'hFF, 12'd0, 8'd0, 8'd0,
			1'b1, STATUS_SEQ, 8'd0, 12'd0, 8'd0, 8'd0, 1'b0});
		script.push_back({FUNC_READ_START, 8'd0, 12'd0, 8'd0, 8'd0,
			1'b1, STATUS_EMPTY, 8'd0, 12'd0, 8'd0, 8'd0, 1'b0});
		script.push_back({FUNC_SEND_START, 8'd0, 12'd4095, 8'hFF, 8'hFF,
			1'b1, STATUS_NO_ROOM, 8'd0, 12'd0, 8'd0, 8'd0, 1'b0});
		// empty payload commits at once and reads back with last set
		script.push_back({FUNC_SEND_START, 8'd0, 12'd0, 8'hFF, 8'h00,
			1'b1, STATUS_OK, 8'd0, 12'd0, 8'd0, 8'd0, 1'b0});
		script.push_back({FUNC_READ_START, 8'd0, 12'd0, 8'd0, 8'd0,
			1'b1, STATUS_OK, 8'd0, 12'd0, 8'hFF, 8'h00, 1'b1});
		script.push_back({FUNC_READ_BYTE, 8'd0, 12'd0, 8'd0, 8'd0,
			1'b1, STATUS_SEQ, 8'd0, 12'd0, 8'd0, 8'd0, 1'b0});
		script.push_back({FUNC_SEND_START, 8'd0, 12'd3, 8'h00, 8'hFF, FROM_MODEL});
		script.push_back({FUNC_SEND_START, 8'd0, 12'd1, 8'h11, 8'h22,
			1'b1, STATUS_SEQ, 8'd0, 12'd0, 8'd0, 8'd0, 1'b0});
		// bytes of an open send are not yet visible
		script.push_back({FUNC_READ_START, 8'd0, 12'd0, 8'd0, 8'd0,
			1'b1, STATUS_EMPTY, 8'd0, 12'd0, 8'd0, 8'd0, 1'b0});
		script.push_back({FUNC_SEND_BYTE, 8'h00, 12'd0, 8'd0, 8'd0, FROM_MODEL});
		script.push_back({FUNC_SEND_BYTE, 8'hFF, 12'd0, 8'd0, 8'd0, FROM_MODEL});
		script.push_back({FUNC_READ_START, 8'd0, 12'd0, 8'd0, 8'd0,
			1'b1, STATUS_EMPTY, 8'd0, 12'd0, 8'd0, 8'd0, 1'b0});
		script.push_back({FUNC_SEND_BYTE, 8'h81, 12'd0, 8'd0, 8'd0, FROM_MODEL});
		script.push_back({FUNC_READ_START, 8'd0, 12'd0, 8'd0, 8'd0,
			1'b1, STATUS_OK, 8'd0, 12'd3, 8'h00, 8'hFF, 1'b0});
		script.push_back({FUNC_READ_START, 8'd0, 12'd0, 8'd0, 8'd0,
			1'b1, STATUS_SEQ, 8'd0, 12'd0, 8'd0, 8'd0, 1'b0});
		script.push_back({FUNC_READ_BYTE, 8'd0, 12'd0, 8'd0, 8'd0,
			1'b1, STATUS_OK, 8'h00, 12'd0, 8'd0, 8'd0, 1'b0});
		script.push_back({FUNC_READ_BYTE, 8'd0, 12'd0, 8'd0, 8'd0,
			1'b1, STATUS_OK, 8'hFF, 12'd0, 8'd0, 8'd0, 1'b0});
		script.push_back({FUNC_READ_BYTE, 8'd0, 12'd0, 8'd0, 8'd0,
			1'b1, STATUS_OK, 8'h81, 12'd0, 8'd0, 8'd0, 1'b1});
		script.push_back({FUNC_READ_BYTE, 8'd0, 12'd0, 8'd0, 8'd0,
			1'b1, STATUS_SEQ, 8'd0, 12'd0, 8'd0, 8'd0, 1'b0});
		script.push_back({FUNC_READ_START, 8'd0, 12'd0, 8'd0, 8'd0,
			1'b1, STATUS_EMPTY, 8'd0, 12'd0, 8'd0, 8'd0, 1'b0});

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (script[k]) begin
			r = script[k];
			apply_item(r.cmd, r.typed, r.want);
		end
		run_phase(PHASE_ITEMS, 1'b0);
		foreach (size_list[k]) begin
			set_ring_size(size_list[k]);
			run_phase(PHASE_ITEMS, k == $size(size_list) - 1);
		end

		while (results_due.size() != 0) @(posedge clk);
		repeat (HDR_LEN + 12) @(posedge clk);
		$display("Ran %0d items over %0d ring sizes (clamped extremes included).",
			n_items, n_sizes);
		$display("Checked %0d results: %0d accepted, %0d refused with an error status.",
			n_results, n_ok, n_refused);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fmru_pkg.sv
rtl/fmru_ram.sv
rtl/fmru_ctrl.sv
rtl/fmru_dp.sv
rtl/framed_message_ring_unit.sv
test/tb_top.sv
